/* hdl/fvn_pkg.sv */
package fvn_pkg;

  localparam int MAX_OCTAVES_DEF = 8;

  localparam int POS_W      = 16;
  localparam int VAL_W      = 16;
  localparam int PROD_W     = 33;
  localparam int AMP_W      = 17;
  localparam int FRAC_W     = 16;
  localparam int SMOOTH_W   = 17;
  localparam int DIV_STEPS  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQUENCY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED     = 2'd3;

  localparam logic [3:0]  OCTAVE_COUNT_RST   = 4'd3;
  localparam logic [15:0] BASE_FREQUENCY_RST = 16'd512;
  localparam logic [15:0] PERSISTENCE_RST    = 16'd32768;
  localparam logic [31:0] NOISE_SEED_RST     = 32'd0;

  localparam logic [31:0] HASH_X    = 32'd374761393;
  localparam logic [31:0] HASH_Y    = 32'd668265263;
  localparam logic [31:0] HASH_Z    = 32'd1274126177;
  localparam logic [31:0] MIX_1     = 32'd1103515245;
  localparam logic [31:0] MIX_2     = 32'd2654435761;
  localparam logic [31:0] SEED_STEP = 32'd31;
  localparam logic [AMP_W-1:0] AMP_ONE = 17'd65536;
  localparam logic [17:0] SMOOTH_K = 18'd196608;
  localparam logic [VAL_W-1:0] VAL_POS_MAX = 16'h7FFF;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int s);
    return 32'($signed(x) >>> s);
  endfunction

  function automatic logic [31:0] corner_const(input int k);
    logic [31:0] c;
    c = 32'd0;
    if ((k & 1) != 0) c = c + HASH_X;
    if ((k & 2) != 0) c = c + HASH_Y;
    if ((k & 4) != 0) c = c + HASH_Z;
    return c;
  endfunction

  function automatic logic signed [VAL_W-1:0] lerp(input logic signed [VAL_W-1:0] a,
                                                    input logic signed [VAL_W-1:0] b,
                                                    input logic [SMOOTH_W-1:0] t);
    logic signed [VAL_W:0]   d;
    logic signed [SMOOTH_W:0] ts;
    logic signed [34:0]      pr;
    logic signed [34:0]      sum;
    d   = 17'(b) - 17'(a);
    ts  = $signed({1'b0, t});
    pr  = 35'(d) * 35'(ts);
    sum = 35'(a) + (pr >>> 16);
    return sum[VAL_W-1:0];
  endfunction

endpackage

/* hdl/fvn_in_if.sv */
interface fvn_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

/* hdl/fvn_out_if.sv */
interface fvn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

/* hdl/fvn_octave.sv */
module fvn_octave #(
  parameter int OCT = 0
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [31:0]                          seed,
  input  logic [2:0][fvn_pkg::PROD_W-1:0]      prod,
  output logic signed [fvn_pkg::VAL_W-1:0]     val
);

  logic [2:0][31:0]                  lat;
  logic [2:0][fvn_pkg::FRAC_W-1:0]   frac;
  logic [2:0][31:0]                  mul_r;
  logic [2:0][31:0]                  f2_r;
  logic [2:0][17:0]                  w_r;
  logic [31:0]                       base_r;
  logic [fvn_pkg::SMOOTH_W-1:0]      tp_r [0:6][0:2];
  logic [31:0]                       a_r [0:7];
  logic [31:0]                       b_r [0:7];
  logic [31:0]                       d_r [0:7];
  logic signed [fvn_pkg::VAL_W-1:0]  v_r [0:7];
  logic signed [fvn_pkg::VAL_W-1:0]  x_r [0:3];
  logic signed [fvn_pkg::VAL_W-1:0]  y_r [0:1];
  logic signed [fvn_pkg::VAL_W-1:0]  z_r;

  always_comb begin
    logic [55:0] sh;
    for (int a = 0; a < 3; a++) begin
      sh      = {{(56 - fvn_pkg::PROD_W){prod[a][fvn_pkg::PROD_W-1]}}, prod[a]} << OCT;
      lat[a]  = sh[54:23];
      frac[a] = sh[22:7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_r[0] <= lat[0] * fvn_pkg::HASH_X;
      mul_r[1] <= lat[1] * fvn_pkg::HASH_Y;
      mul_r[2] <= lat[2] * fvn_pkg::HASH_Z;
      for (int a = 0; a < 3; a++) begin
        f2_r[a] <= 32'(frac[a]) * 32'(frac[a]);
        w_r[a]  <= fvn_pkg::SMOOTH_K - {1'b0, frac[a], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [49:0] p;
    if (en) begin
      base_r <= mul_r[0] + mul_r[1] + mul_r[2] + seed
                + fvn_pkg::SEED_STEP * 32'(OCT);
      for (int a = 0; a < 3; a++) begin
        p           = 50'(f2_r[a]) * 50'(w_r[a]);
        tp_r[0][a] <= p[48:32];
      end
      for (int s = 1; s < 7; s++) begin
        for (int a = 0; a < 3; a++) begin
          tp_r[s][a] <= tp_r[s-1][a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] n;
    logic [31:0] e;
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        n      = base_r + fvn_pkg::corner_const(k);
        a_r[k] <= n ^ fvn_pkg::asr32(n, 13);
        b_r[k] <= a_r[k] * fvn_pkg::MIX_1;
        d_r[k] <= (b_r[k] ^ fvn_pkg::asr32(b_r[k], 16)) * fvn_pkg::MIX_2;
        e      = d_r[k] ^ fvn_pkg::asr32(d_r[k], 16);
        v_r[k] <= {~e[30], e[29:15]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        x_r[j] <= fvn_pkg::lerp(v_r[2*j], v_r[2*j+1], tp_r[4][0]);
      end
      y_r[0] <= fvn_pkg::lerp(x_r[0], x_r[1], tp_r[5][1]);
      y_r[1] <= fvn_pkg::lerp(x_r[2], x_r[3], tp_r[5][1]);
      z_r    <= fvn_pkg::lerp(y_r[0], y_r[1], tp_r[6][2]);
    end
  end

  assign val = z_r;

endmodule

/* hdl/fractal_value_noise_3d_core.sv */
// Channel  Direction  Payload                    Handshake
// in_ch    input      pos_x, pos_y, pos_z        valid/ready
// out_ch   output     noise_value                valid/ready
// cfg      input      cfg_idx, cfg_wdata         cfg_we, no wait
//
// One transaction per cycle while the output is not stalled.
// The pipeline holds the position scaling and octave datapath (10 stages), one
// accumulate stage per octave and a 16-stage restoring divider by the amplitude sum.
// rst_n is synchronous; it clears the valid bits and sets the configuration registers to their reset values.
// A stalled output freezes the whole data pipeline; in_ch.ready is low only then.
module fractal_value_noise_3d_core #(
  parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  fvn_in_if.sink                           in_ch,
  fvn_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [fvn_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [fvn_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int ACC_W  = fvn_pkg::PROD_W + $clog2(MAX_OCTAVES) + 1;
  localparam int ASUM_W = fvn_pkg::AMP_W + $clog2(MAX_OCTAVES + 1);
  localparam int NSTG   = 10 + MAX_OCTAVES + 1 + fvn_pkg::DIV_STEPS;
  localparam int DIV_W  = ACC_W + fvn_pkg::DIV_STEPS;
  localparam int Q_W    = fvn_pkg::DIV_STEPS;

  logic [3:0]  oct_cnt_r;
  logic [15:0] base_freq_r;
  logic [15:0] persist_r;
  logic [31:0] seed_r;

  logic        en;
  logic [NSTG-1:0] vld_r;
  logic        out_valid_r;
  logic signed [fvn_pkg::VAL_W-1:0] out_data_r;

  logic [4:0]  cnt_eff;
  logic [fvn_pkg::AMP_W-1:0] amp_v [0:MAX_OCTAVES-1];
  logic [fvn_pkg::AMP_W-1:0] amp_w [0:MAX_OCTAVES-1];
  logic [ASUM_W-1:0]         asum_r [0:MAX_OCTAVES-1];

  logic [2:0][fvn_pkg::PROD_W-1:0]  prod_r;
  logic signed [fvn_pkg::VAL_W-1:0] val_o [0:MAX_OCTAVES-1];
  logic signed [fvn_pkg::VAL_W-1:0] vv_r [0:MAX_OCTAVES-1][0:MAX_OCTAVES-1];
  logic signed [ACC_W-1:0]          acc_r [0:MAX_OCTAVES-1];

  logic              neg_r [0:Q_W];
  logic [ACC_W-1:0]  rem_r [0:Q_W];
  logic [Q_W-1:0]    q_r   [0:Q_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cnt_r   <= fvn_pkg::OCTAVE_COUNT_RST;
      base_freq_r <= fvn_pkg::BASE_FREQUENCY_RST;
      persist_r   <= fvn_pkg::PERSISTENCE_RST;
      seed_r      <= fvn_pkg::NOISE_SEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fvn_pkg::REG_OCTAVE_COUNT:   oct_cnt_r   <= cfg_wdata[3:0];
        fvn_pkg::REG_BASE_FREQUENCY: base_freq_r <= cfg_wdata[15:0];
        fvn_pkg::REG_PERSISTENCE:    persist_r   <= cfg_wdata[15:0];
        fvn_pkg::REG_NOISE_SEED:     seed_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (oct_cnt_r == 4'd0) begin
      cnt_eff = 5'd1;
    end else if ({1'b0, oct_cnt_r} > 5'(MAX_OCTAVES)) begin
      cnt_eff = 5'(MAX_OCTAVES);
    end else begin
      cnt_eff = {1'b0, oct_cnt_r};
    end
  end

  assign amp_v[0] = fvn_pkg::AMP_ONE;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_amp
    if (i > 0) begin : g_link
      logic [fvn_pkg::AMP_W-1:0] amp_r;
      logic [32:0] amp_p;
      assign amp_p = 33'(amp_v[i-1]) * 33'(persist_r);
      always_ff @(posedge clk) begin
        amp_r <= amp_p[32:16];
      end
      assign amp_v[i] = amp_r;
    end
    assign amp_w[i] = (5'(i) < cnt_eff) ? amp_v[i] : '0;
    if (i == 0) begin : g_sum_first
      always_ff @(posedge clk) begin
        asum_r[i] <= ASUM_W'(amp_w[i]);
      end
    end else begin : g_sum_next
      always_ff @(posedge clk) begin
        asum_r[i] <= asum_r[i-1] + ASUM_W'(amp_w[i]);
      end
    end
  end

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NSTG-2:0], in_ch.valid};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0] <= fvn_pkg::PROD_W'(in_ch.pos_x) * $signed({1'b0, base_freq_r});
      prod_r[1] <= fvn_pkg::PROD_W'(in_ch.pos_y) * $signed({1'b0, base_freq_r});
      prod_r[2] <= fvn_pkg::PROD_W'(in_ch.pos_z) * $signed({1'b0, base_freq_r});
    end
  end

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    fvn_octave #(
      .OCT (i)
    ) u_oct (
      .clk  (clk),
      .en   (en),
      .seed (seed_r),
      .prod (prod_r),
      .val  (val_o[i])
    );
  end

  for (genvar j = 0; j < MAX_OCTAVES; j++) begin : g_acc
    logic signed [fvn_pkg::VAL_W-1:0] vsel;
    logic signed [ACC_W-1:0]          wprod;
    assign wprod = ACC_W'(vsel) * $signed({1'b0, amp_w[j]});
    if (j == 0) begin : g_first
      assign vsel = val_o[0];
      always_ff @(posedge clk) begin
        if (en) begin
          acc_r[j] <= wprod;
          vv_r[j]  <= val_o;
        end
      end
    end else begin : g_next
      assign vsel = vv_r[j-1][j];
      always_ff @(posedge clk) begin
        if (en) begin
          acc_r[j] <= acc_r[j-1] + wprod;
          vv_r[j]  <= vv_r[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= acc_r[MAX_OCTAVES-1][ACC_W-1];
      rem_r[0] <= acc_r[MAX_OCTAVES-1][ACC_W-1] ? ACC_W'(-acc_r[MAX_OCTAVES-1])
                                                : ACC_W'(acc_r[MAX_OCTAVES-1]);
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    logic [DIV_W-1:0] dv;
    assign dv = DIV_W'(asum_r[MAX_OCTAVES-1]) << (Q_W - 1 - k);
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[k+1] <= neg_r[k];
        if (DIV_W'(rem_r[k]) >= dv) begin
          rem_r[k+1] <= rem_r[k] - dv[ACC_W-1:0];
          q_r[k+1]   <= q_r[k] | (Q_W'(1) << (Q_W - 1 - k));
        end else begin
          rem_r[k+1] <= rem_r[k];
          q_r[k+1]   <= q_r[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[Q_W]) begin
        out_data_r <= fvn_pkg::VAL_W'(-q_r[Q_W]);
      end else if (q_r[Q_W] > Q_W'(fvn_pkg::VAL_POS_MAX)) begin
        out_data_r <= fvn_pkg::VAL_POS_MAX;
      end else begin
        out_data_r <= q_r[Q_W];
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.noise_value = out_data_r;

endmodule
